FILE: rtl/salwc_pkg.sv
`timescale 1ns / 1ps
package salwc_pkg;

  // Operation codes carried in the input tuser field
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_STORE = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;
  localparam logic [1:0] OP_UNDEF = 2'd3;  // reserved: changes no line state or counter, but still yields a result word

  localparam int CNT_W = 32;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;     // latch the input word and read its set
    logic access;   // resolve the lookup, update the set, emit a result
    logic clr_wr;   // clear the row under the sweep counter
    logic fl_rd;    // read the row under the sweep counter
    logic fl_wr;    // count dirty lines of the row read, clear it, advance
    logic fl_emit;  // emit the flush result
  } salwc_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_free;    // result register empty or being taken
    logic sweep_last;  // sweep counter is on the last set
    logic in_flush;    // the offered input word is a flush
  } salwc_sts_t;

  // Add and clamp at the counter maximum
  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
  endfunction

endpackage

FILE: rtl/salwc_ctrl.sv
`timescale 1ns / 1ps
module salwc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  salwc_pkg::salwc_sts_t sts,
  output salwc_pkg::salwc_cmd_t cmd
);

  localparam logic [2:0] ST_CLR    = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_LOOK   = 3'd2;
  localparam logic [2:0] ST_FL_RD  = 3'd3;
  localparam logic [2:0] ST_FL_WR  = 3'd4;
  localparam logic [2:0] ST_FL_EMT = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_tready = (state == ST_IDLE);

  // Decode state into commands and pick the next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = sts.in_flush ? ST_FL_RD : ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (sts.out_free) begin
          cmd.access = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_FL_RD: begin
        cmd.fl_rd  = 1'b1;
        state_next = ST_FL_WR;
      end
      ST_FL_WR: begin
        cmd.fl_wr  = 1'b1;
        state_next = sts.sweep_last ? ST_FL_EMT : ST_FL_RD;
      end
      ST_FL_EMT: begin
        if (sts.out_free) begin
          cmd.fl_emit = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/salwc_dp.sv
`timescale 1ns / 1ps
module salwc_dp #(
  parameter int NUM_SETS    = 64,
  parameter int WAYS        = 4,
  parameter int BLOCK_BYTES = 32,
  parameter int LINE_WORDS  = 8,
  parameter int ADDR_BITS   = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [31:0]           addr_in,
  input  logic [1:0]            op_in,
  input  salwc_pkg::salwc_cmd_t cmd,
  output salwc_pkg::salwc_sts_t sts,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [167:0]          m_tdata
);

  localparam int OFF  = $clog2(BLOCK_BYTES);
  localparam int SETB = $clog2(NUM_SETS);
  localparam int SW   = (SETB > 0) ? SETB : 1;
  localparam int TAGW = ADDR_BITS - OFF - SETB;
  localparam int AW   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int FCW  = $clog2(WAYS + 1);
  localparam int CW   = salwc_pkg::CNT_W;

  // Per-set line state, one row per set
  logic [WAYS-1:0][TAGW-1:0] tag_mem   [NUM_SETS];
  logic [WAYS-1:0]           valid_mem [NUM_SETS];
  logic [WAYS-1:0]           dirty_mem [NUM_SETS];
  logic [WAYS-1:0][AW-1:0]   age_mem   [NUM_SETS];

  logic [WAYS-1:0][TAGW-1:0] rd_tag;
  logic [WAYS-1:0]           rd_val;
  logic [WAYS-1:0]           rd_dirty;
  logic [WAYS-1:0][AW-1:0]   rd_age;

  logic [ADDR_BITS-1:0] a_in;
  logic [SW-1:0]        set_in;
  logic [TAGW-1:0]      tag_in;
  logic [1:0]           op_r;
  logic [SW-1:0]        set_r;
  logic [TAGW-1:0]      tag_r;
  logic [SW-1:0]        sweep;
  logic                 fl_wb;

  logic [CW-1:0] acc_total, miss_total, repl_total, fetch_total, copy_total;

  // Split the incoming address
  assign a_in   = addr_in[ADDR_BITS-1:0];
  assign set_in = SW'(a_in >> OFF) & SW'(NUM_SETS - 1);
  assign tag_in = TAGW'(a_in >> (OFF + SETB));

  assign sts.out_free   = !m_tvalid || m_tready;
  assign sts.sweep_last = (sweep == SW'(NUM_SETS - 1));
  assign sts.in_flush   = (op_in == salwc_pkg::OP_FLUSH);

  // Lookup, victim choice and new row contents
  logic                      op_ok, is_store, found, free_found, victim_found;
  logic [AW-1:0]             hit_way, free_way, victim_way, slot, age_h;
  logic [WAYS-1:0]           n_val, n_dirty;
  logic [WAYS-1:0][AW-1:0]   n_age;
  logic [WAYS-1:0][TAGW-1:0] n_tag;
  logic                      r_hit, r_repl, r_wb;
  logic [CW-1:0]             acc_n, miss_n, repl_n, fetch_n, copy_n;

  always_comb begin
    op_ok        = (op_r == salwc_pkg::OP_LOAD) || (op_r == salwc_pkg::OP_STORE);
    is_store     = (op_r == salwc_pkg::OP_STORE);
    found        = 1'b0;
    free_found   = 1'b0;
    victim_found = 1'b0;
    hit_way      = '0;
    free_way     = '0;
    victim_way   = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (rd_val[w] && rd_tag[w] == tag_r && !found) begin
        found   = 1'b1;
        hit_way = AW'(w);
      end
      if (!rd_val[w] && !free_found) begin
        free_found = 1'b1;
        free_way   = AW'(w);
      end
      if (rd_val[w] && rd_age[w] == AW'(WAYS - 1) && !victim_found) begin
        victim_found = 1'b1;
        victim_way   = AW'(w);
      end
    end
    age_h   = rd_age[hit_way];
    slot    = free_found ? free_way : victim_way;
    n_val   = rd_val;
    n_dirty = rd_dirty;
    n_age   = rd_age;
    n_tag   = rd_tag;
    r_hit   = 1'b0;
    r_repl  = 1'b0;
    r_wb    = 1'b0;
    acc_n   = acc_total;
    miss_n  = miss_total;
    repl_n  = repl_total;
    fetch_n = fetch_total;
    copy_n  = copy_total;
    if (op_ok) begin
      acc_n = salwc_pkg::sat_add(acc_total, CW'(1));
      if (found) begin
        r_hit = 1'b1;
        for (int w = 0; w < WAYS; w++) begin
          if (rd_val[w] && rd_age[w] < age_h) n_age[w] = rd_age[w] + AW'(1);
        end
        n_age[hit_way] = '0;
        if (is_store) n_dirty[hit_way] = 1'b1;
      end else begin
        miss_n  = salwc_pkg::sat_add(miss_total, CW'(1));
        fetch_n = salwc_pkg::sat_add(fetch_total, CW'(LINE_WORDS));
        if (!free_found) begin
          r_repl      = 1'b1;
          repl_n      = salwc_pkg::sat_add(repl_total, CW'(1));
          r_wb        = rd_dirty[slot];
          if (rd_dirty[slot]) begin
            copy_n = salwc_pkg::sat_add(copy_total, CW'(LINE_WORDS));
          end
          n_val[slot] = 1'b0;
        end
        for (int w = 0; w < WAYS; w++) begin
          if (n_val[w]) n_age[w] = rd_age[w] + AW'(1);
        end
        n_val[slot]   = 1'b1;
        n_tag[slot]   = tag_r;
        n_dirty[slot] = is_store;
        n_age[slot]   = '0;
      end
    end
  end

  // Count dirty valid lines of a swept row
  logic [FCW-1:0] fl_cnt;
  logic [CW-1:0]  fl_copy;
  always_comb begin
    fl_cnt = '0;
    for (int w = 0; w < WAYS; w++) begin
      fl_cnt = fl_cnt + FCW'(rd_val[w] && rd_dirty[w]);
    end
    fl_copy = salwc_pkg::sat_add(copy_total, CW'(fl_cnt) * CW'(LINE_WORDS));
  end

  // Row memories: one read and one write address per cycle
  always_ff @(posedge clk) begin
    if (cmd.load || cmd.fl_rd) begin
      rd_tag   <= tag_mem[cmd.load ? set_in : sweep];
      rd_val   <= valid_mem[cmd.load ? set_in : sweep];
      rd_dirty <= dirty_mem[cmd.load ? set_in : sweep];
      rd_age   <= age_mem[cmd.load ? set_in : sweep];
    end
    if (cmd.access && op_ok) begin
      tag_mem[set_r]   <= n_tag;
      valid_mem[set_r] <= n_val;
      dirty_mem[set_r] <= n_dirty;
      age_mem[set_r]   <= n_age;
    end else if (cmd.clr_wr || cmd.fl_wr) begin
      valid_mem[sweep] <= '0;
      dirty_mem[sweep] <= '0;
      age_mem[sweep]   <= '0;
    end
  end

  // Latch the accepted word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= op_in;
      set_r <= set_in;
      tag_r <= tag_in;
    end
  end

  // Sweep counter, counters and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep       <= '0;
      fl_wb       <= 1'b0;
      acc_total   <= '0;
      miss_total  <= '0;
      repl_total  <= '0;
      fetch_total <= '0;
      copy_total  <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cmd.load) begin
        sweep <= '0;
        fl_wb <= 1'b0;
      end else if (cmd.clr_wr || cmd.fl_wr) begin
        sweep <= sts.sweep_last ? '0 : sweep + SW'(1);
      end
      if (cmd.fl_wr) begin
        copy_total <= fl_copy;
        if (fl_cnt != '0) fl_wb <= 1'b1;
      end
      if (cmd.access) begin
        acc_total   <= acc_n;
        miss_total  <= miss_n;
        repl_total  <= repl_n;
        fetch_total <= fetch_n;
        copy_total  <= copy_n;
      end
      if (cmd.access || cmd.fl_emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.access) begin
      m_tdata <= {5'd0, copy_n, fetch_n, repl_n, miss_n, acc_n, r_wb, r_repl, r_hit};
    end else if (cmd.fl_emit) begin
      m_tdata <= {5'd0, copy_total, fetch_total, repl_total, miss_total, acc_total,
                  fl_wb, 1'b0, 1'b0};
    end
  end

  a_miss_le_acc: assert property (@(posedge clk) disable iff (rst)
    miss_total <= acc_total) else $error("miss count above access count");
  a_repl_le_miss: assert property (@(posedge clk) disable iff (rst)
    repl_total <= miss_total) else $error("replacement count above miss count");
  a_acc_mono: assert property (@(posedge clk) disable iff (rst)
    acc_total >= $past(acc_total)) else $error("access count went down");
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.access || cmd.fl_emit) |=> m_tvalid) else $error("result not presented");

endmodule

FILE: rtl/set_assoc_lru_writeback_cache.sv
`timescale 1ns / 1ps
// Load or store: the set is read on accept, then the lookup and set update run and
// register the result once the result register is free; input waits while the lookup resolves.
// Flush: set by set, each row is read, its dirty lines counted and cleared, then a result.
// Reset: after rst falls, a clearing pass over every set zeros line state; no
// word is accepted until it ends. Counters and handshake state clear at once.
module set_assoc_lru_writeback_cache #(
  parameter int NUM_SETS    = 64,
  parameter int WAYS        = 4,
  parameter int BLOCK_BYTES = 32,
  parameter int LINE_WORDS  = 8,
  parameter int ADDR_BITS   = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // address[31:0]
  input  logic [1:0]   s_tuser,   // operation[1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  // hit[0], replaced[1], wrote_back[2], access_count[34:3], miss_count[66:35],
  // replacement_count[98:67], fetched_words[130:99], copied_back_words[162:131]
  output logic [167:0] m_tdata
);

  salwc_pkg::salwc_cmd_t cmd;
  salwc_pkg::salwc_sts_t sts;

  salwc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  salwc_dp #(
    .NUM_SETS    (NUM_SETS),
    .WAYS        (WAYS),
    .BLOCK_BYTES (BLOCK_BYTES),
    .LINE_WORDS  (LINE_WORDS),
    .ADDR_BITS   (ADDR_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .addr_in  (s_tdata),
    .op_in    (s_tuser),
    .cmd      (cmd),
    .sts      (sts),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

FILE: tb/sv/set_assoc_lru_writeback_cache_checker.sv
`timescale 1ns / 1ps
module set_assoc_lru_writeback_cache_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [31:0]  s_tdata,
  input  logic [1:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [167:0] m_tdata,
  output int           fail_count,
  output int           pending
);

  localparam int SETS = 64;
  localparam int WAYS = 4;
  localparam int OFF_BITS = 5;
  localparam int SET_BITS = 6;
  localparam logic [31:0] BLOCK_WORDS = 32'd8;

  typedef struct packed {
    logic [31:0] copied;
    logic [31:0] fetched;
    logic [31:0] repls;
    logic [31:0] misses;
    logic [31:0] accesses;
    logic        wrote_back;
    logic        replaced;
    logic        hit;
  } cache_result_t;

  // Shadow of the tag store and the counters
  logic [20:0] tag_mem [SETS][WAYS];
  logic        valid_mem [SETS][WAYS];
  logic        dirty_mem [SETS][WAYS];
  int unsigned age_mem [SETS][WAYS];
  logic [31:0] n_access, n_miss, n_repl, n_fetch, n_copy;

  cache_result_t expected_q[$];

  function automatic logic [31:0] clamp_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Apply one access to the shadow and return the expected result word
  function automatic cache_result_t model_access(logic [1:0] op, logic [31:0] addr);
    cache_result_t r;
    int set, found, free_w, victim, age;
    logic [20:0] tag;
    r = '0;
    found = -1;
    free_w = -1;
    victim = -1;
    if (op == salwc_pkg::OP_FLUSH) begin
      for (int s = 0; s < SETS; s++)
        for (int w = 0; w < WAYS; w++) begin
          if (valid_mem[s][w] && dirty_mem[s][w]) begin
            n_copy = clamp_add(n_copy, BLOCK_WORDS);
            r.wrote_back = 1'b1;
          end
          valid_mem[s][w] = 1'b0;
          dirty_mem[s][w] = 1'b0;
          age_mem[s][w] = 0;
        end
    end else if (op != salwc_pkg::OP_UNDEF) begin
      set = int'(addr[OFF_BITS +: SET_BITS]);
      tag = addr[31 -: 21];
      n_access = clamp_add(n_access, 32'd1);
      for (int w = 0; w < WAYS; w++) begin
        if (valid_mem[set][w]) begin
          if (found < 0 && tag_mem[set][w] == tag) found = w;
          if (victim < 0 || age_mem[set][w] > age_mem[set][victim]) victim = w;
        end else if (free_w < 0) begin
          free_w = w;
        end
      end
      if (found >= 0) begin
        age = age_mem[set][found];
        for (int w = 0; w < WAYS; w++)
          if (valid_mem[set][w] && age_mem[set][w] < age) age_mem[set][w]++;
        age_mem[set][found] = 0;
        if (op == salwc_pkg::OP_STORE) dirty_mem[set][found] = 1'b1;
        r.hit = 1'b1;
      end else begin
        n_miss = clamp_add(n_miss, 32'd1);
        n_fetch = clamp_add(n_fetch, BLOCK_WORDS);
        if (free_w < 0) begin
          free_w = victim;
          r.replaced = 1'b1;
          n_repl = clamp_add(n_repl, 32'd1);
          if (dirty_mem[set][victim]) begin
            r.wrote_back = 1'b1;
            n_copy = clamp_add(n_copy, BLOCK_WORDS);
          end
          valid_mem[set][victim] = 1'b0;
        end
        for (int w = 0; w < WAYS; w++)
          if (valid_mem[set][w] && age_mem[set][w] < 255) age_mem[set][w]++;
        valid_mem[set][free_w] = 1'b1;
        tag_mem[set][free_w] = tag;
        dirty_mem[set][free_w] = (op == salwc_pkg::OP_STORE);
        age_mem[set][free_w] = 0;
      end
    end
    r.accesses = n_access;
    r.misses = n_miss;
    r.repls = n_repl;
    r.fetched = n_fetch;
    r.copied = n_copy;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  // Predict on input words, compare on output words
  always @(posedge clk) begin
    cache_result_t got, want;
    if (rst) begin
      for (int s = 0; s < SETS; s++)
        for (int w = 0; w < WAYS; w++) begin
          valid_mem[s][w] = 1'b0;
          dirty_mem[s][w] = 1'b0;
          age_mem[s][w] = 0;
        end
      n_access = '0;
      n_miss = '0;
      n_repl = '0;
      n_fetch = '0;
      n_copy = '0;
      expected_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = cache_result_t'(m_tdata[162:0]);
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result word", got.accesses, '0);
        end else begin
          want = expected_q.pop_front();
          if (got.hit != want.hit) report_mismatch("hit", got.hit, want.hit);
          if (got.replaced != want.replaced)
            report_mismatch("replaced", got.replaced, want.replaced);
          if (got.wrote_back != want.wrote_back)
            report_mismatch("wrote_back", got.wrote_back, want.wrote_back);
          if (got.accesses != want.accesses)
            report_mismatch("access_count", got.accesses, want.accesses);
          if (got.misses != want.misses)
            report_mismatch("miss_count", got.misses, want.misses);
          if (got.repls != want.repls)
            report_mismatch("replacement_count", got.repls, want.repls);
          if (got.fetched != want.fetched)
            report_mismatch("fetched_words", got.fetched, want.fetched);
          if (got.copied != want.copied)
            report_mismatch("copied_back_words", got.copied, want.copied);
        end
      end
      if (s_tvalid && s_tready) expected_q.push_back(model_access(s_tuser, s_tdata));
    end
    pending = expected_q.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
  end

endmodule

FILE: tb/sv/set_assoc_lru_writeback_cache_tb.sv
`timescale 1ns / 1ps
module set_assoc_lru_writeback_cache_tb;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [31:0]  s_tdata;
  logic [1:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [167:0] m_tdata;
  int           fail_count;
  int           pending;
  logic         hold_off;

  set_assoc_lru_writeback_cache uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  set_assoc_lru_writeback_cache_checker chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Build an address from set, tag and offset
  function automatic logic [31:0] make_addr(int set, logic [20:0] tag);
    return {tag, 6'(set), 5'($urandom_range(0, 31))};
  endfunction

  // Offer one word after a random gap and hold it until taken
  task automatic send_word(logic [1:0] op, logic [31:0] addr);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= addr;
    do @(posedge clk); while (!s_tready);
  endtask

  // Receiver: random stall per word, plus one long hold-off
  initial begin
    int stall;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_off) begin
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin
    logic [20:0] tags [8];
    int set, op_pick;
    logic [1:0] op;
    hold_off = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = salwc_pkg::OP_LOAD;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: address extremes, all ops, eviction with dirty victim, flush
    send_word(salwc_pkg::OP_LOAD, 32'h0000_0000);
    send_word(salwc_pkg::OP_STORE, 32'hFFFF_FFFF);
    send_word(salwc_pkg::OP_LOAD, 32'hFFFF_FFE0);
    send_word(salwc_pkg::OP_UNDEF, 32'hA5A5_5A5A);
    for (int i = 0; i < 6; i++) send_word(salwc_pkg::OP_STORE, make_addr(3, 21'(i + 1)));
    send_word(salwc_pkg::OP_LOAD, make_addr(3, 21'd5));
    send_word(salwc_pkg::OP_LOAD, make_addr(3, 21'd1));
    send_word(salwc_pkg::OP_FLUSH, 32'h5555_AAAA);
    send_word(salwc_pkg::OP_FLUSH, 32'hAAAA_5555);
    send_word(salwc_pkg::OP_LOAD, 32'h0000_0000);

    // Long receiver hold-off while words keep coming
    hold_off = 1'b1;
    for (int i = 0; i < 10; i++) send_word(salwc_pkg::OP_STORE, make_addr(i, 21'd7));

    // Random: mostly hot tags in few sets so hits and evictions mix
    for (int i = 0; i < 8; i++) tags[i] = 21'($urandom);
    for (int i = 0; i < 750; i++) begin
      op_pick = $urandom_range(0, 99);
      op = (op_pick < 50) ? salwc_pkg::OP_LOAD : (op_pick < 95) ? salwc_pkg::OP_STORE :
           (op_pick < 98) ? salwc_pkg::OP_FLUSH : salwc_pkg::OP_UNDEF;
      set = $urandom_range(0, 3) == 0 ? $urandom_range(0, 63) : $urandom_range(0, 3);
      if ($urandom_range(0, 9) == 0) send_word(op, $urandom);
      else send_word(op, make_addr(set, tags[$urandom_range(0, 7)]));
    end
    s_tvalid <= 1'b0;

    // Drain
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("set_assoc_lru_writeback_cache test passed");
    else $display("set_assoc_lru_writeback_cache test failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("set_assoc_lru_writeback_cache test failed");
    $finish;
  end

endmodule

FILE: files.f
rtl/salwc_pkg.sv
rtl/salwc_ctrl.sv
rtl/salwc_dp.sv
rtl/set_assoc_lru_writeback_cache.sv
tb/sv/set_assoc_lru_writeback_cache_checker.sv
tb/sv/set_assoc_lru_writeback_cache_tb.sv
